@@ rtl/core/mexp_pkg.sv @@
// shared constants for the modular exponentiation block
// no dependencies; imported by the interfaces and every module
package mexp_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 32;

endpackage

@@ rtl/core/mexp_in_if.sv @@
// input channel of the modular exponentiation block: valid, ready and operands
// depends on mexp_pkg
interface mexp_in_if
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
);

  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] base_value;
  logic [OPERAND_WIDTH-1:0] exponent;
  logic [OPERAND_WIDTH-1:0] modulus;

  modport source (output valid, output base_value, output exponent, output modulus,
                  input ready);
  modport sink   (input valid, input base_value, input exponent, input modulus,
                  output ready);

endinterface

@@ rtl/core/mexp_out_if.sv @@
// result channel of the modular exponentiation block: valid, ready and result
// depends on mexp_pkg
interface mexp_out_if
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
);

  logic                     valid;
  logic                     ready;
  logic [OPERAND_WIDTH-1:0] power_result;
  logic                     bad_modulus;

  modport source (output valid, output power_result, output bad_modulus, input ready);
  modport sink   (input valid, input power_result, input bad_modulus, output ready);

endinterface

@@ rtl/core/mexp_mod_step.sv @@
// shared arithmetic unit: one double-and-add step reduced modulo the modulus
// result = (2 * acc + addend) mod modulus, with acc and addend below modulus
// depends on mexp_pkg
module mexp_mod_step
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic [OPERAND_WIDTH-1:0] acc_i,
  input  logic [OPERAND_WIDTH-1:0] addend_i,
  input  logic [OPERAND_WIDTH-1:0] modulus_i,
  output logic [OPERAND_WIDTH-1:0] result_o
);

  localparam int unsigned SumWidth = OPERAND_WIDTH + 2;

  logic [SumWidth-1:0] sum;
  logic [SumWidth-1:0] mod_x1;
  logic [SumWidth-1:0] mod_x2;
  logic [SumWidth-1:0] diff_x1;
  logic [SumWidth-1:0] diff_x2;

  // sum stays below three times the modulus, so one of three candidates fits
  always_comb begin
    sum     = {1'b0, acc_i, 1'b0} + {2'b00, addend_i};
    mod_x1  = {2'b00, modulus_i};
    mod_x2  = {1'b0, modulus_i, 1'b0};
    diff_x1 = sum - mod_x1;
    diff_x2 = sum - mod_x2;
    if (sum >= mod_x2) begin
      result_o = diff_x2[OPERAND_WIDTH-1:0];
    end else if (sum >= mod_x1) begin
      result_o = diff_x1[OPERAND_WIDTH-1:0];
    end else begin
      result_o = sum[OPERAND_WIDTH-1:0];
    end
  end

endmodule

@@ rtl/core/modular_exponentiation.sv @@
// modular exponentiation, top level: sequencer around the shared step unit
// depends on mexp_pkg, mexp_in_if, mexp_out_if and mexp_mod_step
//
// usage
// - in_i beat carries base_value, exponent and modulus; out_o beat carries
//   power_result and bad_modulus, one result beat for every input beat
// - in_i.ready is high only while the sequencer is idle; one item at a time
// - a zero modulus answers 0 with bad_modulus set; a modulus of one answers 0
// - otherwise the base is first reduced one bit a cycle, then for
//   each of the W exponent bits, low bit first, a modular multiply (only when
//   the bit is set) and a modular square, each a series of steps on the step unit
// - throughput is set by the single double-and-add unit: one step a cycle
// - the result sits in an output register, so a new item is taken while the
//   previous result waits; if the receiver still stalls when the next result
//   is done, the sequencer holds it and stays not ready
// - reset clears the sequencer and the output valid; no item is in flight
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mexp_in_if.sink         in_i,
  mexp_out_if.source      out_o
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(OPERAND_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_e;

  state_e          state_q;
  logic [W-1:0]    mod_q;
  logic [W-1:0]    base_q;
  logic [W-1:0]    exp_q;
  logic [W-1:0]    acc_q;
  logic [W-1:0]    sq_q;
  logic [W-1:0]    prod_q;
  logic [W-1:0]    mult_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] ecnt_q;
  logic [W-1:0]    res_q;
  logic            bad_q;
  logic            out_valid_q;
  logic [W-1:0]    out_result_q;
  logic            out_bad_q;

  logic [W-1:0]    addend;
  logic [W-1:0]    step;
  logic            out_load;

  always_comb begin
    case (state_q)
      ST_RED:  addend = {{(W-1){1'b0}}, base_q[W-1]};
      ST_MUL:  addend = mult_q[W-1] ? acc_q : '0;
      ST_SQR:  addend = mult_q[W-1] ? sq_q : '0;
      default: addend = '0;
    endcase
  end

  mexp_mod_step #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_step (
    .acc_i    (prod_q),
    .addend_i (addend),
    .modulus_i(mod_q),
    .result_o (step)
  );

  // hand over once the output register is free or being emptied
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_o.ready);

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.power_result = out_result_q;
  assign out_o.bad_modulus  = out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            mod_q  <= in_i.modulus;
            base_q <= in_i.base_value;
            exp_q  <= in_i.exponent;
            acc_q  <= {{(W-1){1'b0}}, 1'b1};
            prod_q <= '0;
            cnt_q  <= CntLast;
            ecnt_q <= '0;
            // modulus of zero or one needs no arithmetic
            if (in_i.modulus[W-1:1] == '0) begin
              res_q   <= '0;
              bad_q   <= ~in_i.modulus[0];
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_RED;
            end
          end
        end
        ST_RED: begin
          base_q <= {base_q[W-2:0], 1'b0};
          if (cnt_q == '0) begin
            sq_q    <= step;
            mult_q  <= step;
            prod_q  <= '0;
            cnt_q   <= CntLast;
            state_q <= exp_q[0] ? ST_MUL : ST_SQR;
          end else begin
            prod_q <= step;
            cnt_q  <= cnt_q - CntW'(1);
          end
        end
        ST_MUL: begin
          if (cnt_q == '0) begin
            acc_q   <= step;
            mult_q  <= sq_q;
            prod_q  <= '0;
            cnt_q   <= CntLast;
            state_q <= ST_SQR;
          end else begin
            prod_q <= step;
            mult_q <= {mult_q[W-2:0], 1'b0};
            cnt_q  <= cnt_q - CntW'(1);
          end
        end
        ST_SQR: begin
          if (cnt_q == '0) begin
            sq_q   <= step;
            mult_q <= step;
            prod_q <= '0;
            cnt_q  <= CntLast;
            exp_q  <= {1'b0, exp_q[W-1:1]};
            if (ecnt_q == CntLast) begin
              res_q   <= acc_q;
              bad_q   <= 1'b0;
              state_q <= ST_FIN;
            end else begin
              ecnt_q  <= ecnt_q + CntW'(1);
              state_q <= exp_q[1] ? ST_MUL : ST_SQR;
            end
          end else begin
            prod_q <= step;
            mult_q <= {mult_q[W-2:0], 1'b0};
            cnt_q  <= cnt_q - CntW'(1);
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_result_q <= res_q;
            out_bad_q    <= bad_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_prod_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR) |-> (prod_q < mod_q))
    else $error("step accumulator not below modulus");

  a_sq_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL || state_q == ST_SQR) |-> (sq_q < mod_q))
    else $error("square operand not below modulus");

  a_bad_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_result_q == '0))
    else $error("bad modulus result not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("ready again right after an accepted beat");
`endif

endmodule

@@ verif/tb_modular_exponentiation.sv @@
// self-checking bench for modular_exponentiation: directed and random operands,
// random idling on both channels, scoreboard with its own power predictor
// depends on mexp_pkg, mexp_in_if, mexp_out_if and the block under test
module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam int unsigned W          = OPERAND_WIDTH_DEF;
  localparam int unsigned LONG_HOLD  = 6000;
  localparam int unsigned STUCK_MAX  = 20000;
  localparam int unsigned TAIL_WAIT  = 2100;
  localparam int unsigned RAND_FIRST = 120;
  localparam int unsigned RAND_MID   = 100;
  localparam int unsigned RAND_LAST  = 40;

  typedef logic [W-1:0] word_t;

  typedef struct {
    word_t base_value;
    word_t exponent;
    word_t modulus;
    word_t power_result;
    logic  bad_modulus;
  } power_expect_t;

  class power_scoreboard;
    power_expect_t expected_powers[$];
    int unsigned   errors;

    function new();
      errors = 0;
    endfunction

    // right-to-left square and multiply; 32-bit operands keep products exact in 64 bits
    function power_expect_t predict_power(word_t b, word_t e, word_t m);
      power_expect_t   p;
      longint unsigned md;
      longint unsigned acc;
      longint unsigned sq;
      p.base_value   = b;
      p.exponent     = e;
      p.modulus      = m;
      p.bad_modulus  = 1'b0;
      p.power_result = '0;
      if (m == '0) begin
        p.bad_modulus = 1'b1;
      end else if (m != word_t'(1)) begin
        md  = longint'(m);
        acc = 1;
        sq  = longint'(b) % md;
        for (int i = 0; i < W; i++) begin
          if (e[i]) acc = (acc * sq) % md;
          sq = (sq * sq) % md;
        end
        p.power_result = word_t'(acc);
      end
      return p;
    endfunction

    function void note_operands(word_t b, word_t e, word_t m);
      expected_powers.push_back(predict_power(b, e, m));
    endfunction

    function int unsigned pending_count();
      return expected_powers.size();
    endfunction

    task report_mismatch(input string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(input word_t got_power, input logic got_bad);
      power_expect_t p;
      if (expected_powers.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h bad=%b", got_power, got_bad));
      end else begin
        p = expected_powers.pop_front();
        if (got_power !== p.power_result || got_bad !== p.bad_modulus)
          report_mismatch($sformatf("%h^%h mod %h: got %h bad=%b, want %h bad=%b",
                                    p.base_value, p.exponent, p.modulus, got_power,
                                    got_bad, p.power_result, p.bad_modulus));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_ni;
  logic quiet;
  logic long_hold_req;

  power_scoreboard sb = new();

  mexp_in_if  #(.OPERAND_WIDTH(W)) in_ch ();
  mexp_out_if #(.OPERAND_WIDTH(W)) out_ch ();

  modular_exponentiation #(.OPERAND_WIDTH(W)) dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk = ~clk;

  // result beats
  always @(posedge clk) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.power_result, out_ch.bad_modulus);
  end

  // receiver: short random stalls, one long hold-off on request, none once quiet
  initial begin
    int unsigned stall_left;
    bit          long_done;
    stall_left = 0;
    long_done  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_done) begin
        long_done  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_MAX) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("tb_modular_exponentiation: done, errors");
    $finish;
  end

  // may first idle valid for a random gap; holds it after the accepting edge for the caller to lower
  task automatic send_operands(input word_t b, input word_t e, input word_t m);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= b;
    in_ch.exponent   <= e;
    in_ch.modulus    <= m;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_operands(b, e, m);
  endtask

  task automatic wait_results_drained();
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic send_random_operands();
    word_t b;
    word_t e;
    word_t m;
    int unsigned kind;
    b    = $urandom;
    e    = $urandom;
    m    = $urandom;
    kind = $urandom_range(0, 99);
    if (kind >= 50 && kind < 65) begin
      m = $urandom_range(2, 1000);
    end else if (kind >= 65 && kind < 75) begin
      m = $urandom_range(0, 1);
    end else if (kind >= 75 && kind < 85) begin
      e = $urandom_range(0, 15);
    end else if (kind >= 85 && kind < 93) begin
      // base at or above the modulus, unless the modulus plus the offset wraps
      m = $urandom | (word_t'(1) << (W - 1));
      b = ($urandom_range(0, 1) == 0) ? m + word_t'($urandom_range(0, 1000)) : '1;
    end else if (kind >= 93) begin
      case ($urandom_range(0, 2))
        0:       b = '0;
        1:       b = word_t'(1);
        default: b = m - word_t'(1);
      endcase
    end
    send_operands(b, e, m);
  endtask

  initial begin
    rst_ni = 1'b0;
    quiet         <= 1'b0;
    long_hold_req <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.base_value <= '0;
    in_ch.exponent   <= '0;
    in_ch.modulus    <= '0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // zero modulus, modulus of one, zero exponent, zero base, unreduced base, extremes
    send_operands(32'd5, 32'd3, 32'd0);
    send_operands(32'd0, 32'd0, 32'd0);
    send_operands('1, '1, 32'd0);
    send_operands(32'd7, 32'd9, 32'd1);
    send_operands('1, '1, 32'd1);
    send_operands(32'd123, 32'd0, 32'd2);
    send_operands(32'd0, 32'd0, '1);
    send_operands(32'd0, 32'd5, 32'd97);
    send_operands(32'd0, '1, '1);
    send_operands(32'd1000, 32'd3, 32'd7);
    send_operands('1, '1, '1);
    send_operands(32'hffff_fffe, '1, '1);
    send_operands(32'd2, 32'd31, 32'hffff_fffb);
    send_operands(32'd3, '1, 32'd2);
    send_operands('1, 32'd2, 32'hffff_fffe);
    send_operands(32'd12345, 32'd65537, 32'h8000_0001);
    send_operands(32'h8000_0000, 32'd1, 32'h8000_0001);
    send_operands(32'd5, 32'd1, 32'd3);
    send_operands(32'h8000_0001, 32'h8000_0000, 32'h8000_0001);
    in_ch.valid <= 1'b0;
    wait_results_drained();

    repeat (RAND_FIRST) send_random_operands();

    // receiver holds off while beats keep coming, so the block backs up
    long_hold_req <= 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i < 6) send_operands($urandom, $urandom, word_t'($urandom_range(0, 1)));
      else       send_operands($urandom, $urandom, $urandom);
    end
    in_ch.valid <= 1'b0;
    wait_results_drained();

    repeat (RAND_MID) send_random_operands();

    quiet <= 1'b1;
    repeat (RAND_LAST) send_random_operands();
    in_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (TAIL_WAIT) @(posedge clk);

    if (sb.pending_count() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending_count()));
    if (sb.errors == 0)
      $display("tb_modular_exponentiation: done, clean");
    else
      $display("tb_modular_exponentiation: done, errors");
    $finish;
  end

endmodule
